// ===== design/maf_pkg.sv =====
// shared types and constants for the moving average filter
package maf_pkg;

  localparam int MafWindow      = 16;
  localparam int MafSampleWidth = 16;
  localparam int QueueDepth     = 2;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_CLEAR  = 1'b1
  } maf_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } maf_state_t;

endpackage

// ===== design/maf_ram.sv =====
// generic single write port, single read port ram with registered read
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/maf_front.sv =====
// front end: accepts input transfers, classifies the command and queues items
module maf_front import maf_pkg::*; #(
  parameter int SAMPLE_WIDTH = MafSampleWidth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           item_valid,
  output maf_cmd_t                       item_cmd,
  output logic signed [SAMPLE_WIDTH-1:0] item_sample,
  input  logic                           item_pop
);

  localparam int QPTR_W = $clog2(QueueDepth);
  localparam int QCNT_W = $clog2(QueueDepth + 1);

  maf_cmd_t                       cmd_q    [QueueDepth];
  logic signed [SAMPLE_WIDTH-1:0] sample_q [QueueDepth];
  logic [QPTR_W-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]              count_r, count_nxt;
  logic                           push;
  logic                           pop;

  assign in_stall    = (count_r == QCNT_W'(QueueDepth));
  assign push        = in_valid && !in_stall;
  assign item_valid  = (count_r != '0);
  assign pop         = item_pop && item_valid;
  assign item_cmd    = cmd_q[rd_ptr_r];
  assign item_sample = sample_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]    <= in_cmd ? CMD_CLEAR : CMD_FILTER;
      sample_q[wr_ptr_r] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/maf_div.sv =====
// radix-2 restoring divider, signed dividend by unsigned count, truncates toward zero
module maf_div import maf_pkg::*; #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 5,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [Q_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              neg_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  quo_signed;

  assign mag    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});
  assign diff   = rem_sh - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= mag;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = quo_signed[Q_W-1:0];
  assign done       = done_r;

endmodule

// ===== design/maf_back.sv =====
// back end: ring buffer update, running sum, divide sequencing and result register
module maf_back import maf_pkg::*; #(
  parameter int WINDOW       = MafWindow,
  parameter int SAMPLE_WIDTH = MafSampleWidth
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         item_valid,
  input  maf_cmd_t                                     item_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]               item_sample,
  output logic                                         item_pop,
  output logic                                         ram_wr_en,
  output logic [$clog2(WINDOW)-1:0]                    ram_wr_addr,
  output logic [SAMPLE_WIDTH-1:0]                      ram_wr_data,
  output logic                                         ram_rd_en,
  output logic [$clog2(WINDOW)-1:0]                    ram_rd_addr,
  input  logic [SAMPLE_WIDTH-1:0]                      ram_rd_data,
  output logic                                         div_start,
  output logic signed [SAMPLE_WIDTH+$clog2(WINDOW)-1:0] div_dividend,
  output logic [$clog2(WINDOW+1)-1:0]                  div_divisor,
  input  logic                                         div_done,
  input  logic signed [SAMPLE_WIDTH-1:0]               div_quotient,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]               out_average,
  output logic                                         out_window_full
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + IDX_W;

  maf_state_t                     state_r, state_nxt;
  logic signed [SUM_W-1:0]        sum_r, sum_nxt;
  logic [IDX_W-1:0]               ptr_r, ptr_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] res_r;
  logic signed [SAMPLE_WIDTH-1:0] avg_r;
  logic                           full_r;
  logic                           full;
  logic                           out_free;
  logic                           load_out;
  logic signed [SUM_W-1:0]        x_ext;
  logic signed [SUM_W-1:0]        old_ext;

  assign full     = (cnt_r == CNT_W'(WINDOW));
  assign out_free = !out_valid_r || !out_stall;
  assign x_ext    = {{IDX_W{x_r[SAMPLE_WIDTH-1]}}, x_r};
  assign old_ext  = full ? {{IDX_W{ram_rd_data[SAMPLE_WIDTH-1]}}, ram_rd_data} : '0;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    item_pop      = 1'b0;
    ram_rd_en     = 1'b0;
    ram_wr_en     = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item_cmd == CMD_CLEAR) begin
            sum_nxt = '0;
            ptr_nxt = '0;
            cnt_nxt = '0;
          end else begin
            ram_rd_en = 1'b1;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        // drop the overwritten sample once the window is full
        sum_nxt   = sum_r + x_ext - old_ext;
        ram_wr_en = 1'b1;
        ptr_nxt   = (ptr_r == IDX_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        cnt_nxt   = full ? cnt_r : cnt_r + 1'b1;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign ram_rd_addr  = ptr_r;
  assign ram_wr_addr  = ptr_r;
  assign ram_wr_data  = x_r;
  assign div_dividend = sum_nxt;
  assign div_divisor  = cnt_nxt;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      x_r <= item_sample;
    end
    if (div_done) begin
      res_r <= div_quotient;
    end
    if (load_out) begin
      avg_r  <= res_r;
      full_r <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = avg_r;
  assign out_window_full = full_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= IDX_W'(WINDOW - 1))
    else $error("ring index beyond window");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && item_valid && item_cmd == CMD_CLEAR)
      |=> (cnt_r == '0 && sum_r == '0 && ptr_r == '0))
    else $error("clear did not empty the window");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_ptr_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (CNT_W'(ptr_r) == cnt_r))
    else $error("ring index out of step with fill count");

endmodule

// ===== design/moving_average_filter_core.sv =====
// moving average filter core: sliding window mean over a ring buffer with running sum
// per sample the back end reads the oldest sample, updates the running sum and ring buffer,
// then the radix-2 divider forms the mean, one quotient bit per cycle; a clear needs no divide
// an input transfer is registered in the queue before the back end can take it
// a two-entry input queue and the result register let each side stall on its own
// rst_n is synchronous, active low; it empties the window; ram contents are not cleared
module moving_average_filter_core import maf_pkg::*; #(
  parameter int WINDOW       = MafWindow,
  parameter int SAMPLE_WIDTH = MafSampleWidth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_average,
  output logic                           out_window_full
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + IDX_W;

  logic                           item_valid;
  maf_cmd_t                       item_cmd;
  logic signed [SAMPLE_WIDTH-1:0] item_sample;
  logic                           item_pop;
  logic                           ram_wr_en;
  logic [IDX_W-1:0]               ram_wr_addr;
  logic [SAMPLE_WIDTH-1:0]        ram_wr_data;
  logic                           ram_rd_en;
  logic [IDX_W-1:0]               ram_rd_addr;
  logic [SAMPLE_WIDTH-1:0]        ram_rd_data;
  logic                           div_start;
  logic signed [SUM_W-1:0]        div_dividend;
  logic [CNT_W-1:0]               div_divisor;
  logic                           div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_quotient;

  maf_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_sample   (in_sample),
    .item_valid  (item_valid),
    .item_cmd    (item_cmd),
    .item_sample (item_sample),
    .item_pop    (item_pop)
  );

  maf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  maf_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .Q_W   (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  maf_back #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_cmd        (item_cmd),
    .item_sample     (item_sample),
    .item_pop        (item_pop),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quotient    (div_quotient),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .out_window_full (out_window_full)
  );

endmodule
